// ===== sv/pei_pkg.sv =====
// ============================================================================
// pei_pkg
// Shared constants, command and status types and saturation helper for the
// particle Euler integrator.
// ============================================================================
package pei_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned DT_W        = 16;
  localparam int unsigned TF_W        = 16;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned IN_DATA_W   = 144;
  localparam int unsigned OUT_DATA_W  = 144;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned WIDE_W      = 66;

  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_FAC = 2'd2;

  localparam logic [TF_W-1:0] TIME_FAC_RESET = 16'd256;

  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic latch;
    logic gen;
    logic issue;
    logic first;
    logic publish;
  } pei_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic pipe_busy;
    logic out_free;
  } pei_status_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] upper;
    upper = v[WIDE_W-1:VAL_W-1];
    if (upper == '0 || upper == '1) begin
      sat32 = v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

endpackage

// ===== sv/pei_ctrl.sv =====
// ============================================================================
// pei_ctrl
// Sequencer for item acceptance, generate, increment setup, store sweep,
// pipeline drain and result hand-off.
// ============================================================================
module pei_ctrl #(
  parameter int unsigned Capacity = pei_pkg::CAPACITY,
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_cmd_i,
  output logic                s_ready_o,
  input  pei_pkg::pei_status_t status_i,
  input  logic [CntW-1:0]     count_i,
  output pei_pkg::pei_cmd_t   cmd_o,
  output logic [IdxW-1:0]     addr_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GEN   = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_INC   = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last;

  assign last   = (CntW'(idx_q) == (count_i - CntW'(1)));
  assign addr_o = idx_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        idx_d     = '0;
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          if (s_cmd_i == pei_pkg::CMD_GEN) begin
            state_d = ST_GEN;
          end else if (status_i.count_zero) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_GEN: begin
        cmd_o.gen = 1'b1;
        state_d   = ST_DONE;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_INC;
      ST_INC:  state_d = ST_SWEEP;
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (idx_q == '0);
        if (last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== sv/pei_datapath.sv =====
// ============================================================================
// pei_datapath
// Particle stores, configuration registers, increment multipliers, the
// per-particle update pipeline, bounding box and result register.
// ============================================================================
module pei_datapath #(
  parameter int unsigned Capacity = pei_pkg::CAPACITY,
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pei_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pei_pkg::VAL_W-1:0]            cfg_wdata_i,
  input  logic [pei_pkg::IN_DATA_W-1:0]        s_data_i,
  input  logic                                 s_cmd_i,
  input  pei_pkg::pei_cmd_t                    cmd_i,
  input  logic [IdxW-1:0]                      addr_i,
  output pei_pkg::pei_status_t                 status_o,
  output logic [CntW-1:0]                      count_o,
  input  logic                                 m_ready_i,
  output logic                                 m_valid_o,
  output logic [pei_pkg::OUT_DATA_W-1:0]       m_data_o
);

  localparam int unsigned VW = pei_pkg::VAL_W;
  localparam int unsigned WW = pei_pkg::WIDE_W;
  localparam int unsigned PW = 49;

  // configuration
  logic signed [VW-1:0]         force_x_q, force_y_q;
  logic [pei_pkg::TF_W-1:0]     tf_q;

  // latched item
  logic                         item_cmd_q;
  logic signed [VW-1:0]         in_px_q, in_py_q, in_vx_q, in_vy_q;
  logic [pei_pkg::DT_W-1:0]     dt_q;

  // ring state
  logic [CntW-1:0]              count_q;
  logic [IdxW-1:0]              wslot_q;
  logic                         over_q;

  // stores
  logic signed [VW-1:0]         mem_px [Capacity];
  logic signed [VW-1:0]         mem_py [Capacity];
  logic signed [VW-1:0]         mem_vx [Capacity];
  logic signed [VW-1:0]         mem_vy [Capacity];

  // increment
  logic signed [PW-1:0]         pf_x_q, pf_y_q;
  logic signed [WW-1:0]         pt_x_q, pt_y_q;
  logic signed [VW-1:0]         inc_x_q, inc_y_q;
  logic signed [PW-1:0]         dt_s, tf_s_n;
  logic signed [WW-1:0]         tf_s;

  // pipeline
  logic                         v1_q, v2_q, v3_q, v4_q;
  logic                         f1_q, f2_q, f3_q, f4_q;
  logic [IdxW-1:0]              idx1_q, idx2_q, idx3_q;
  logic signed [VW-1:0]         px1_q, py1_q, vx1_q, vy1_q;
  logic signed [VW-1:0]         px2_q, py2_q, vx2_q, vy2_q;
  logic signed [VW-1:0]         px3_q, py3_q, vx3_q, vy3_q;
  logic signed [PW-1:0]         prx3_q, pry3_q;
  logic signed [PW-1:0]         rnd_x, rnd_y;
  logic signed [VW-1:0]         npx, npy;
  logic signed [VW-1:0]         ox4_q, oy4_q, nx4_q, ny4_q;

  // bounding box
  logic signed [VW-1:0]         blx_q, bly_q, bhx_q, bhy_q;
  logic signed [VW-1:0]         lo_x, lo_y, hi_x, hi_y;

  // result
  logic                         m_valid_q;
  logic [pei_pkg::OUT_DATA_W-1:0] m_data_q;
  logic [CntW+pei_pkg::COUNT_OUT_W-1:0] cnt_ext;
  logic                         step_valid;

  assign dt_s   = PW'(signed'({1'b0, dt_q}));
  assign tf_s_n = PW'(signed'({1'b0, tf_q}));
  assign tf_s   = WW'(tf_s_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_x_q <= '0;
      force_y_q <= '0;
      tf_q      <= pei_pkg::TIME_FAC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pei_pkg::CFG_FORCE_X:  force_x_q <= cfg_wdata_i;
        pei_pkg::CFG_FORCE_Y:  force_y_q <= cfg_wdata_i;
        pei_pkg::CFG_TIME_FAC: tf_q      <= cfg_wdata_i[pei_pkg::TF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_cmd_q <= s_cmd_i;
      in_px_q    <= s_data_i[31:0];
      in_py_q    <= s_data_i[63:32];
      in_vx_q    <= s_data_i[95:64];
      in_vy_q    <= s_data_i[127:96];
      dt_q       <= s_data_i[143:128];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wslot_q <= '0;
      over_q  <= 1'b0;
    end else if (cmd_i.gen) begin
      if (count_q < CntW'(Capacity)) begin
        count_q <= count_q + CntW'(1);
        over_q  <= 1'b0;
      end else begin
        over_q  <= 1'b1;
      end
      if (wslot_q == IdxW'(Capacity - 1)) begin
        wslot_q <= '0;
      end else begin
        wslot_q <= wslot_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pf_x_q  <= PW'(force_x_q) * dt_s;
    pf_y_q  <= PW'(force_y_q) * dt_s;
    pt_x_q  <= WW'(pf_x_q) * tf_s;
    pt_y_q  <= WW'(pf_y_q) * tf_s;
    inc_x_q <= pei_pkg::sat32((pt_x_q + WW'(524288)) >>> 20);
    inc_y_q <= pei_pkg::sat32((pt_y_q + WW'(524288)) >>> 20);
  end

  assign rnd_x = (prx3_q + PW'(2048)) >>> 12;
  assign rnd_y = (pry3_q + PW'(2048)) >>> 12;
  assign npx   = pei_pkg::sat32(WW'(px3_q) + WW'(rnd_x));
  assign npy   = pei_pkg::sat32(WW'(py3_q) + WW'(rnd_y));

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen) begin
      mem_px[wslot_q] <= in_px_q;
      mem_py[wslot_q] <= in_py_q;
      mem_vx[wslot_q] <= in_vx_q;
      mem_vy[wslot_q] <= in_vy_q;
    end else if (v3_q) begin
      mem_px[idx3_q] <= npx;
      mem_py[idx3_q] <= npy;
      mem_vx[idx3_q] <= vx3_q;
      mem_vy[idx3_q] <= vy3_q;
    end
    if (cmd_i.issue) begin
      px1_q <= mem_px[addr_i];
      py1_q <= mem_py[addr_i];
      vx1_q <= mem_vx[addr_i];
      vy1_q <= mem_vy[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= cmd_i.first;
    idx1_q <= addr_i;
    f2_q   <= f1_q;
    idx2_q <= idx1_q;
    px2_q  <= px1_q;
    py2_q  <= py1_q;
    vx2_q  <= pei_pkg::sat32(WW'(vx1_q) + WW'(inc_x_q));
    vy2_q  <= pei_pkg::sat32(WW'(vy1_q) + WW'(inc_y_q));
    f3_q   <= f2_q;
    idx3_q <= idx2_q;
    px3_q  <= px2_q;
    py3_q  <= py2_q;
    vx3_q  <= vx2_q;
    vy3_q  <= vy2_q;
    prx3_q <= PW'(vx2_q) * dt_s;
    pry3_q <= PW'(vy2_q) * dt_s;
    f4_q   <= f3_q;
    ox4_q  <= px3_q;
    oy4_q  <= py3_q;
    nx4_q  <= npx;
    ny4_q  <= npy;
  end

  assign lo_x = (ox4_q < nx4_q) ? ox4_q : nx4_q;
  assign hi_x = (ox4_q > nx4_q) ? ox4_q : nx4_q;
  assign lo_y = (oy4_q < ny4_q) ? oy4_q : ny4_q;
  assign hi_y = (oy4_q > ny4_q) ? oy4_q : ny4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blx_q <= '0;
      bly_q <= '0;
      bhx_q <= '0;
      bhy_q <= '0;
    end else if (v4_q) begin
      if (f4_q) begin
        blx_q <= lo_x;
        bly_q <= lo_y;
        bhx_q <= hi_x;
        bhy_q <= hi_y;
      end else begin
        blx_q <= (lo_x < blx_q) ? lo_x : blx_q;
        bly_q <= (lo_y < bly_q) ? lo_y : bly_q;
        bhx_q <= (hi_x > bhx_q) ? hi_x : bhx_q;
        bhy_q <= (hi_y > bhy_q) ? hi_y : bhy_q;
      end
    end
  end

  assign cnt_ext    = {{pei_pkg::COUNT_OUT_W{1'b0}}, count_q};
  assign step_valid = (item_cmd_q == pei_pkg::CMD_STEP) && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      if (item_cmd_q == pei_pkg::CMD_GEN) begin
        m_data_q <= {5'd0, over_q, cnt_ext[pei_pkg::COUNT_OUT_W-1:0], 1'b0, 128'd0};
      end else begin
        m_data_q <= {5'd0, 1'b0, cnt_ext[pei_pkg::COUNT_OUT_W-1:0], step_valid,
                     bhy_q, bhx_q, bly_q, blx_q};
      end
    end
  end

  assign m_valid_o           = m_valid_q;
  assign m_data_o            = m_data_q;
  assign count_o             = count_q;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.pipe_busy  = v1_q | v2_q | v3_q | v4_q;
  assign status_o.out_free   = !m_valid_q || m_ready_i;

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.gen && v3_q))
    else $error("generate write collides with sweep write-back");

  a_wb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (CntW'(idx3_q) < count_q))
    else $error("write-back beyond occupied slots");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("occupancy decreased");

  a_over_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> (count_q == CntW'(Capacity)))
    else $error("overwrite flagged while ring not full");
`endif

endmodule

// ===== sv/particle_euler_integrator_top.sv =====
// ============================================================================
// particle_euler_integrator_top
// Fixed-point particle ring with semi-implicit Euler step and bounding box.
// ============================================================================
// One item is processed at a time and every item returns one result beat.
// A generate beat stores the latched particle and returns its result. A step
// beat on a non-empty ring first forms the force increments through two
// registered multipliers, then the sweep reads one particle per cycle from the
// single read port of the stores and writes the updated particle back to the
// same slot, and the pipeline drains before the box is returned. A step on an
// empty ring goes straight to the result. Results wait in an output register;
// a new input beat is taken once the previous result is loaded.
module particle_euler_integrator_top #(
  parameter int unsigned Capacity = pei_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pei_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pei_pkg::VAL_W-1:0]           cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, dt
  input  logic [pei_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // cmd
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // box_low_x, box_low_y, box_high_x, box_high_y, box_valid, particle_count,
  // overwrote, zero pad
  output logic [pei_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  pei_pkg::pei_cmd_t    cmd;
  pei_pkg::pei_status_t status;
  logic [IdxW-1:0]      addr;
  logic [CntW-1:0]      count;

  pei_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_cmd_i  (s_axis_tuser[0]),
    .s_ready_o(s_axis_tready),
    .status_i (status),
    .count_i  (count),
    .cmd_o    (cmd),
    .addr_o   (addr)
  );

  pei_datapath #(
    .Capacity(Capacity)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_data_i   (s_axis_tdata),
    .s_cmd_i    (s_axis_tuser[0]),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .status_o   (status),
    .count_o    (count),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata)
  );

endmodule
